@@ design/dhcp_pkg.sv @@
// Shared types and constants for the DHCP reply frame parser.
`timescale 1ns / 1ps
package dhcp_pkg;
  localparam int MaxFrameBytes = 2048;
  // Byte counters are PosW + 1 bits, enough to hold the frame limit itself.
  localparam int PosW = $clog2(MaxFrameBytes + 1);

  localparam logic [3:0] ST_OK = 4'd0;
  localparam logic [3:0] ST_SHORT = 4'd1;
  localparam logic [3:0] ST_NOT_IPV4 = 4'd2;
  localparam logic [3:0] ST_NOT_UDP = 4'd3;
  localparam logic [3:0] ST_BAD_IHL = 4'd4;
  localparam logic [3:0] ST_PORTS = 4'd5;
  localparam logic [3:0] ST_NOT_REPLY = 4'd6;
  localparam logic [3:0] ST_XID = 4'd7;
  localparam logic [3:0] ST_ZERO_IP = 4'd8;
  localparam logic [3:0] ST_COOKIE = 4'd9;
  localparam logic [3:0] ST_TYPE = 4'd10;
  localparam logic [3:0] ST_TOO_LONG = 4'd11;

  localparam logic REG_XID = 1'b0;
  localparam logic REG_ACK = 1'b1;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [31:0] PORT_PAIR = 32'h00430044;
  localparam logic [31:0] DHCP_COOKIE = 32'h63825363;
  localparam logic [7:0]  PROTO_UDP = 8'd17;
  localparam logic [7:0]  BOOT_REPLY = 8'd2;

  localparam logic [7:0] OPT_PAD = 8'h00;
  localparam logic [7:0] OPT_END = 8'hFF;
  localparam logic [7:0] OPT_MASK = 8'd1;
  localparam logic [7:0] OPT_ROUTER = 8'd3;
  localparam logic [7:0] OPT_DNS = 8'd6;
  localparam logic [7:0] OPT_MSGTYPE = 8'd53;
  localparam logic [7:0] OPT_SERVER = 8'd54;
  localparam logic [7:0] MSG_OFFER = 8'd2;
  localparam logic [7:0] MSG_ACK = 8'd5;

  typedef enum logic [1:0] {PH_TYPE, PH_LEN, PH_VALUE, PH_DONE} opt_phase_t;

  // Item passed from the byte front end to the verdict back end.
  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       counted;   // byte falls within the frame limit
  } byte_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] offered_ip;
    logic [31:0] subnet_mask;
    logic [31:0] gateway_ip;
    logic [31:0] srv_addr;
    logic [31:0] dns_primary;
    logic [31:0] dns_secondary;
  } verdict_t;
endpackage

@@ design/dhcp_front.sv @@
// Front end: accept bytes, mark them against the frame limit, queue them.
`timescale 1ns / 1ps
module dhcp_front import dhcp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       q_valid,
  input  logic       q_ready,
  output byte_item_t q_item
);
  logic [PosW:0] count;
  byte_item_t    mem [2];
  logic          wp, rp;
  logic [1:0]    fill;
  logic          push, pop;

  assign in_ready = (fill != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (fill != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_item = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= '{b: in_byte, last: in_last,
                   counted: (count < (PosW + 1)'(MaxFrameBytes))};
    end
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      fill <= 2'd0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= ~wp;
        if (in_last) count <= '0;
        else if (count < (PosW + 1)'(MaxFrameBytes)) count <= count + 1'b1;
      end
      if (pop) rp <= ~rp;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

@@ design/dhcp_back.sv @@
// Back end: run the header checks and option walk, hold the verdict.
`timescale 1ns / 1ps
module dhcp_back import dhcp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_ready,
  input  byte_item_t  q_item,
  input  logic [31:0] match_xid,
  input  logic        expect_ack,
  output logic        out_valid,
  input  logic        out_ready,
  output verdict_t    out_v
);
  logic [PosW:0] pos;
  logic          too_long;
  logic [3:0]    ihl, fail;
  logic [31:0]   sh, yiaddr, siaddr;
  logic [31:0]   cap [5];
  opt_phase_t    ph;
  logic [7:0]    otype, olen, ocnt, ofirst;
  logic [31:0]   w0, w1;
  logic [1:0]    tm;
  logic          take;

  logic [31:0]   sh_n;
  logic [PosW:0] udp, boot;
  logic [PosW:0] len;

  assign q_ready = !out_valid || out_ready;
  assign take = q_valid && q_ready;
  assign sh_n = {sh[23:0], q_item.b};
  assign udp = (PosW + 1)'(14) + {{(PosW - 5){1'b0}}, ihl, 2'b00};
  assign boot = udp + (PosW + 1)'(8);
  assign len = q_item.counted ? pos + 1'b1 : pos;

  // Fail check is evaluated on the current byte only; the verdict uses the next-state
  // values, so the checks of the last byte itself count toward the verdict.
  logic [3:0] f_now;
  logic [3:0] ihl_now;
  logic [31:0] cap_n [5];
  logic [1:0] tm_n;
  opt_phase_t ph_n;
  logic [7:0] otype_n, olen_n, ocnt_n, ofirst_n;
  logic [31:0] w0_n, w1_n, ya_n, si_n;
  logic [PosW:0] udp_n, boot_n;
  logic [PosW:0] need_n, len_n;
  logic [3:0] stat_n;
  logic opt_commit;
  verdict_t v_n;

  always_comb begin
    f_now = fail;
    ihl_now = ihl;
    cap_n = cap;
    tm_n = tm;
    ph_n = ph;
    otype_n = otype;
    olen_n = olen;
    ocnt_n = ocnt;
    ofirst_n = ofirst;
    w0_n = w0;
    w1_n = w1;
    ya_n = yiaddr;
    si_n = siaddr;
    opt_commit = 1'b0;
    if (q_item.counted && fail == ST_OK) begin
      if (pos == (PosW + 1)'(13) && sh_n[15:0] != ETHERTYPE_IPV4) f_now = ST_NOT_IPV4;
      else if (pos == (PosW + 1)'(14)) ihl_now = q_item.b[3:0];
      else if (pos == (PosW + 1)'(23)) begin
        if (q_item.b != PROTO_UDP) f_now = ST_NOT_UDP;
        else if (ihl < 4'd5) f_now = ST_BAD_IHL;
      end else if (pos >= (PosW + 1)'(34)) begin
        if (pos == udp + (PosW + 1)'(3)) begin
          if (sh_n != PORT_PAIR) f_now = ST_PORTS;
        end else if (pos == boot) begin
          if (q_item.b != BOOT_REPLY) f_now = ST_NOT_REPLY;
        end else if (pos == boot + (PosW + 1)'(7)) begin
          if (sh_n != match_xid) f_now = ST_XID;
        end else if (pos == boot + (PosW + 1)'(19)) begin
          ya_n = sh_n;
          if (sh_n == 32'd0) f_now = ST_ZERO_IP;
        end else if (pos == boot + (PosW + 1)'(23)) begin
          si_n = sh_n;
        end else if (pos == boot + (PosW + 1)'(239)) begin
          if (sh_n != DHCP_COOKIE) f_now = ST_COOKIE;
        end else if (pos >= boot + (PosW + 1)'(240)) begin
          case (ph)
            PH_TYPE: begin
              if (q_item.b == OPT_END) ph_n = PH_DONE;
              else if (q_item.b != OPT_PAD) begin
                otype_n = q_item.b;
                ph_n = PH_LEN;
              end
            end
            PH_LEN: begin
              olen_n = q_item.b;
              ocnt_n = 8'd0;
              if (q_item.b == 8'd0) begin
                opt_commit = 1'b1;
                ph_n = PH_TYPE;
              end else ph_n = PH_VALUE;
            end
            PH_VALUE: begin
              if (ocnt == 8'd0) ofirst_n = q_item.b;
              if (ocnt == 8'd3) w0_n = sh_n;
              if (ocnt == 8'd7) w1_n = sh_n;
              ocnt_n = ocnt + 8'd1;
              if ({1'b0, ocnt} + 9'd1 >= {1'b0, olen}) begin
                opt_commit = 1'b1;
                ph_n = PH_TYPE;
              end
            end
            default: ;
          endcase
          if (opt_commit) begin
            if (otype_n == OPT_MSGTYPE && olen_n >= 8'd1) begin
              if (ofirst_n == MSG_OFFER) tm_n[0] = 1'b1;
              if (ofirst_n == MSG_ACK) tm_n[1] = 1'b1;
            end else if (olen_n >= 8'd4) begin
              case (otype_n)
                OPT_MASK: cap_n[0] = w0_n;
                OPT_ROUTER: cap_n[1] = w0_n;
                OPT_SERVER: cap_n[2] = w0_n;
                OPT_DNS: begin
                  cap_n[3] = w0_n;
                  if (olen_n >= 8'd8) cap_n[4] = w1_n;
                end
                default: ;
              endcase
            end
          end
        end
      end
    end
    udp_n = (PosW + 1)'(14) + {{(PosW - 5){1'b0}}, ihl_now, 2'b00};
    boot_n = udp_n + (PosW + 1)'(8);
    len_n = len;
    case (f_now)
      ST_NOT_IPV4: need_n = (PosW + 1)'(14);
      ST_NOT_UDP, ST_BAD_IHL: need_n = (PosW + 1)'(34);
      ST_PORTS: need_n = boot_n;
      default: need_n = boot_n + (PosW + 1)'(240);
    endcase
    if (too_long || !q_item.counted) stat_n = ST_TOO_LONG;
    else if (f_now != ST_OK) stat_n = (len_n >= need_n) ? f_now : ST_SHORT;
    else if (len_n < boot_n + (PosW + 1)'(240)) stat_n = ST_SHORT;
    else if ((tm_n & (expect_ack ? 2'b10 : 2'b01)) == 2'b00) stat_n = ST_TYPE;
    else stat_n = ST_OK;

    v_n = '0;
    v_n.status = stat_n;
    if (stat_n == ST_OK) begin
      v_n.offered_ip = ya_n;
      v_n.subnet_mask = cap_n[0];
      v_n.gateway_ip = cap_n[1];
      if (!expect_ack) begin
        v_n.srv_addr = (cap_n[2] != 32'd0) ? cap_n[2] : si_n;
        v_n.dns_primary = cap_n[3];
        v_n.dns_secondary = cap_n[4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos <= '0; too_long <= 1'b0; ihl <= '0; fail <= '0; sh <= '0;
      yiaddr <= '0; siaddr <= '0; ph <= PH_TYPE; tm <= '0;
      otype <= '0; olen <= '0; ocnt <= '0; ofirst <= '0; w0 <= '0; w1 <= '0;
      for (int k = 0; k < 5; k++) cap[k] <= '0;
    end else begin
      out_valid <= (take && q_item.last) || (out_valid && !out_ready);
      if (take) begin
        if (q_item.last) begin
          out_v <= v_n;
          pos <= '0; too_long <= 1'b0; ihl <= '0; fail <= '0; sh <= '0;
          yiaddr <= '0; siaddr <= '0; ph <= PH_TYPE; tm <= '0;
          otype <= '0; olen <= '0; ocnt <= '0; ofirst <= '0; w0 <= '0; w1 <= '0;
          for (int k = 0; k < 5; k++) cap[k] <= '0;
        end else if (!q_item.counted) begin
          too_long <= 1'b1;
        end else begin
          pos <= pos + 1'b1;
          sh <= sh_n;
          fail <= f_now; ihl <= ihl_now; yiaddr <= ya_n; siaddr <= si_n;
          ph <= ph_n; tm <= tm_n; otype <= otype_n; olen <= olen_n;
          ocnt <= ocnt_n; ofirst <= ofirst_n; w0 <= w0_n; w1 <= w1_n;
          for (int k = 0; k < 5; k++) cap[k] <= cap_n[k];
        end
      end
    end
  end
endmodule

@@ design/dhcp_reply_frame_parser_unit.sv @@
// Top level: DHCP offer/ack frame parser with config registers.
//   channel  | dir | contents
//   s_axis   | in  | tdata = frame_byte[7:0]; tlast = last_byte
//   m_axis   | out | tdata = status, offered_ip, subnet_mask, gateway_ip,
//            |     |   srv_addr, dns_primary, dns_secondary (low bits first)
//   cfg      | in  | cfg_we, cfg_index, cfg_data (0 match_xid, 1 expect_ack)
// One byte per cycle sustained while the result side is ready; a two-entry queue parts byte intake from the
// check logic, and the verdict sits in an output register.
// Synchronous reset clears frame state and registers.
// A stalled result stalls the check logic; the queue then fills and drops ready.
`timescale 1ns / 1ps
module dhcp_reply_frame_parser_unit import dhcp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // frame_byte
  input  logic         s_axis_tlast,   // last_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [199:0] m_axis_tdata,   // status, offered_ip .. dns_secondary
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);
  logic [31:0] match_xid;
  logic        expect_ack;
  logic        q_valid, q_ready;
  byte_item_t  q_item;
  verdict_t    v;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_xid <= '0;
      expect_ack <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == REG_XID) match_xid <= cfg_data;
      else expect_ack <= cfg_data[0];
    end
  end

  dhcp_front u_front (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_byte(s_axis_tdata), .in_last(s_axis_tlast),
    .q_valid, .q_ready, .q_item
  );

  dhcp_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_item, .match_xid, .expect_ack,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_v(v)
  );

  assign m_axis_tdata = {4'd0, v.dns_secondary, v.dns_primary, v.srv_addr,
                         v.gateway_ip, v.subnet_mask, v.offered_ip, v.status};
endmodule

@@ tb/tb.sv @@
// Testbench for the DHCP reply frame parser: frame stimulus, byte-level predictor, verdict check.
`timescale 1ns / 1ps
module tb;
  import dhcp_pkg::*;

  localparam int CycleLimit = 2000000;
  localparam int HoldCycles = 3000;
  localparam int DrainCycles = 20;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [199:0] m_axis_tdata;
  logic         cfg_we;
  logic         cfg_index;
  logic [31:0]  cfg_data;

  dhcp_reply_frame_parser_unit u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Register copies and frame state of the predictor
  logic [31:0] xid_reg;
  logic        ack_mode;
  int unsigned fr_pos;
  bit          fr_long;
  int unsigned ihl_w;
  logic [3:0]  fail_code;
  logic [31:0] shift_w;
  logic [31:0] yi_addr;
  logic [31:0] si_addr;
  logic [31:0] cap [5];
  opt_phase_t  ph;
  logic [7:0]  o_type, o_first;
  int unsigned o_len, o_count;
  logic [31:0] o_w0, o_w1;
  logic [1:0]  seen_types;

  verdict_t verdict_q [$];
  byte unsigned frm [$];
  int errors = 0;
  int bytes_sent = 0;
  int cycles = 0;
  bit idle_on = 1'b1;
  bit stall_on = 1'b1;
  bit hold_req = 1'b0;

  task automatic clear_frame_state();
    fr_pos = 0; fr_long = 0; ihl_w = 0; fail_code = ST_OK; shift_w = '0;
    yi_addr = '0; si_addr = '0;
    for (int k = 0; k < 5; k++) cap[k] = '0;
    ph = PH_TYPE; o_type = '0; o_len = 0; o_count = 0; o_first = '0;
    o_w0 = '0; o_w1 = '0; seen_types = '0;
  endtask

  task automatic commit_opt();
    if (o_type == OPT_MSGTYPE && o_len >= 1) begin
      if (o_first == MSG_OFFER) seen_types[0] = 1'b1;
      if (o_first == MSG_ACK) seen_types[1] = 1'b1;
    end else if (o_len >= 4) begin
      case (o_type)
        OPT_MASK: cap[0] = o_w0;
        OPT_ROUTER: cap[1] = o_w0;
        OPT_SERVER: cap[2] = o_w0;
        OPT_DNS: begin
          cap[3] = o_w0;
          if (o_len >= 8) cap[4] = o_w1;
        end
        default: ;
      endcase
    end
  endtask

  task automatic walk_option(input logic [7:0] b);
    case (ph)
      PH_TYPE: begin
        if (b == OPT_END) ph = PH_DONE;
        else if (b != OPT_PAD) begin
          o_type = b;
          ph = PH_LEN;
        end
      end
      PH_LEN: begin
        o_len = {24'd0, b};
        o_count = 0;
        if (b == 8'd0) begin
          commit_opt();
          ph = PH_TYPE;
        end else ph = PH_VALUE;
      end
      PH_VALUE: begin
        if (o_count == 0) o_first = b;
        if (o_count == 3) o_w0 = shift_w;
        if (o_count == 7) o_w1 = shift_w;
        o_count++;
        if (o_count >= o_len) begin
          commit_opt();
          ph = PH_TYPE;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_byte(input int unsigned p, input logic [7:0] b);
    int unsigned udp, boot;
    shift_w = {shift_w[23:0], b};
    if (fail_code != ST_OK) return;
    if (p == 13 && shift_w[15:0] != ETHERTYPE_IPV4) begin
      fail_code = ST_NOT_IPV4;
      return;
    end
    if (p == 14) ihl_w = {28'd0, b[3:0]};
    if (p == 23) begin
      if (b != PROTO_UDP) fail_code = ST_NOT_UDP;
      else if (ihl_w < 5) fail_code = ST_BAD_IHL;
      return;
    end
    if (p < 34) return;
    udp = 14 + ihl_w * 4;
    boot = udp + 8;
    if (p == udp + 3) begin
      if (shift_w != PORT_PAIR) fail_code = ST_PORTS;
    end else if (p == boot) begin
      if (b != BOOT_REPLY) fail_code = ST_NOT_REPLY;
    end else if (p == boot + 7) begin
      if (shift_w != xid_reg) fail_code = ST_XID;
    end else if (p == boot + 19) begin
      yi_addr = shift_w;
      if (shift_w == 32'd0) fail_code = ST_ZERO_IP;
    end else if (p == boot + 23) begin
      si_addr = shift_w;
    end else if (p == boot + 239) begin
      if (shift_w != DHCP_COOKIE) fail_code = ST_COOKIE;
    end else if (p >= boot + 240) begin
      walk_option(b);
    end
  endtask

  // Advance the predictor by one accepted item; queue a verdict on the last byte.
  task automatic predict_item(input logic [7:0] b, input logic last);
    verdict_t v;
    int unsigned need, boot;
    if (fr_pos < MaxFrameBytes) begin
      check_byte(fr_pos, b);
      fr_pos++;
    end else fr_long = 1;
    if (!last) return;
    boot = 22 + ihl_w * 4;
    v = '0;
    if (fr_long) v.status = ST_TOO_LONG;
    else if (fail_code != ST_OK) begin
      case (fail_code)
        ST_NOT_IPV4: need = 14;
        ST_NOT_UDP, ST_BAD_IHL: need = 34;
        ST_PORTS: need = boot;
        default: need = boot + 240;
      endcase
      v.status = (fr_pos >= need) ? fail_code : ST_SHORT;
    end else if (fr_pos < boot + 240) v.status = ST_SHORT;
    else if (!(ack_mode ? seen_types[1] : seen_types[0])) v.status = ST_TYPE;
    else v.status = ST_OK;
    if (v.status == ST_OK) begin
      v.offered_ip = yi_addr;
      v.subnet_mask = cap[0];
      v.gateway_ip = cap[1];
      if (!ack_mode) begin
        v.srv_addr = (cap[2] != 32'd0) ? cap[2] : si_addr;
        v.dns_primary = cap[3];
        v.dns_secondary = cap[4];
      end
    end
    verdict_q.push_back(v);
    clear_frame_state();
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    verdict_t w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) report("unexpected result", m_axis_tdata[31:0], '0);
      else begin
        w = verdict_q.pop_front();
        if (m_axis_tdata[3:0] != w.status)
          report("status", {28'd0, m_axis_tdata[3:0]}, {28'd0, w.status});
        if (m_axis_tdata[35:4] != w.offered_ip)
          report("offered_ip", m_axis_tdata[35:4], w.offered_ip);
        if (m_axis_tdata[67:36] != w.subnet_mask)
          report("subnet_mask", m_axis_tdata[67:36], w.subnet_mask);
        if (m_axis_tdata[99:68] != w.gateway_ip)
          report("gateway_ip", m_axis_tdata[99:68], w.gateway_ip);
        if (m_axis_tdata[131:100] != w.srv_addr)
          report("srv_addr", m_axis_tdata[131:100], w.srv_addr);
        if (m_axis_tdata[163:132] != w.dns_primary)
          report("dns_primary", m_axis_tdata[163:132], w.dns_primary);
        if (m_axis_tdata[195:164] != w.dns_secondary)
          report("dns_secondary", m_axis_tdata[195:164], w.dns_secondary);
      end
    end
  end

  // Result side: random stall bursts, and one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else if (stall_on && $urandom_range(0, 11) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic last);
    if (idle_on && $urandom_range(0, 24) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_item(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame(input int cut);
    for (int i = 0; i < cut; i++) send_item(frm[i], i == cut - 1);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] xid, input logic ack);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= REG_XID;
    cfg_data <= xid;
    @(posedge clk);
    cfg_index <= REG_ACK;
    cfg_data <= {31'd0, ack};
    @(posedge clk);
    cfg_we <= 1'b0;
    xid_reg = xid;
    ack_mode = ack;
  endtask

  task automatic push32(input logic [31:0] w);
    for (int k = 3; k >= 0; k--) frm.push_back(w[8*k +: 8]);
  endtask

  task automatic push_opt(input logic [7:0] t, input int len, input logic [31:0] w0);
    frm.push_back(t);
    frm.push_back(8'(len));
    for (int k = 0; k < len; k++)
      frm.push_back(k < 4 ? w0[8*(3-k) +: 8] : 8'($urandom_range(0, 255)));
  endtask

  // Append an end option most of the time, then a few trailing bytes.
  task automatic close_frame();
    if ($urandom_range(0, 3) != 0) frm.push_back(OPT_END);
    repeat ($urandom_range(0, 4)) frm.push_back(8'($urandom_range(0, 255)));
  endtask

  // Build a well-formed reply with random content; ihl below 5 still gets a 20-byte header.
  task automatic build_reply(input int ihl, input logic [31:0] xid, input int mtype,
                             input int n_opts);
    int hl;
    logic [7:0] t;
    frm.delete();
    for (int k = 0; k < 12; k++) frm.push_back(8'($urandom_range(0, 255)));
    frm.push_back(ETHERTYPE_IPV4[15:8]);
    frm.push_back(ETHERTYPE_IPV4[7:0]);
    hl = (ihl < 5) ? 20 : ihl * 4;
    frm.push_back({4'h4, ihl[3:0]});
    for (int k = 1; k < hl; k++)
      frm.push_back(k == 9 ? PROTO_UDP : 8'($urandom_range(0, 255)));
    push32(PORT_PAIR);
    push32($urandom);
    frm.push_back(BOOT_REPLY);
    for (int k = 1; k < 4; k++) frm.push_back(8'($urandom_range(0, 255)));
    push32(xid);
    for (int k = 8; k < 16; k++) frm.push_back(8'($urandom_range(0, 255)));
    push32($urandom | 32'h1);
    push32($urandom_range(0, 1) ? $urandom : 32'h0);
    for (int k = 24; k < 236; k++) frm.push_back(8'($urandom_range(0, 255)));
    push32(DHCP_COOKIE);
    if (mtype >= 0) push_opt(OPT_MSGTYPE, 1, {mtype[7:0], 24'h0});
    for (int n = 0; n < n_opts; n++) begin
      case ($urandom_range(0, 8))
        0: push_opt(OPT_MASK, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 4,
                    $urandom);
        1: push_opt(OPT_ROUTER, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 4,
                    $urandom);
        2: push_opt(OPT_SERVER, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 4,
                    $urandom);
        3: push_opt(OPT_DNS, $urandom_range(0, 1) ? 8 : $urandom_range(0, 12), $urandom);
        4: frm.push_back(OPT_PAD);
        5: push_opt(OPT_MSGTYPE, $urandom_range(0, 2),
                    {5'd0, 3'($urandom_range(0, 7)), 24'h0});
        default: begin
          t = 8'($urandom_range(1, 254));
          push_opt(t, $urandom_range(0, 6), $urandom);
        end
      endcase
    end
  endtask

  function automatic int want_type();
    return ack_mode ? int'(MSG_ACK) : int'(MSG_OFFER);
  endfunction

  task automatic test_directed();
    set_config(32'h0, 1'b0);
    // full offer carrying every captured option
    build_reply(5, xid_reg, want_type(), 0);
    push_opt(OPT_MASK, 4, 32'hFFFFFF00);
    push_opt(OPT_ROUTER, 4, 32'hC0A80001);
    push_opt(OPT_SERVER, 4, 32'h0A000001);
    push_opt(OPT_DNS, 8, 32'h08080808);
    frm.push_back(OPT_END);
    send_frame(frm.size());
    // header failures, each cut just past the stage that reports it
    build_reply(5, xid_reg, want_type(), 0);
    frm[12] = 8'h86;
    send_frame(14);
    frm[12] = ETHERTYPE_IPV4[15:8];
    frm[23] = 8'd6;
    send_frame(34);
    build_reply(4, xid_reg, want_type(), 0);
    send_frame(40);
    build_reply(5, xid_reg, want_type(), 0);
    frm[36] = 8'h44;
    send_frame(42);
    // short frames: one byte, and a reply failure cut before the BOOTP block ends
    send_frame(1);
    frm[36] = 8'h00;
    frm[42] = 8'd1;
    send_frame(60);
    // ack mode with a zero offered address
    set_config(32'hFFFFFFFF, 1'b1);
    build_reply(5, xid_reg, want_type(), 2);
    for (int k = 58; k < 62; k++) frm[k] = 8'h00;
    close_frame();
    send_frame(frm.size());
  endtask

  task automatic test_random();
    int n = 0;
    int len;
    while (bytes_sent < 860) begin
      if (n % 4 == 0) set_config($urandom, 1'($urandom_range(0, 1)));
      n++;
      build_reply(($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : 5,
                  ($urandom_range(0, 9) == 0) ? $urandom : xid_reg,
                  ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : want_type(),
                  $urandom_range(0, 3));
      close_frame();
      if ($urandom_range(0, 2) != 0) send_frame($urandom_range(1, 40));
      else begin
        len = $urandom_range(1, 40);
        frm.delete();
        repeat (len) frm.push_back(8'($urandom_range(0, 255)));
        send_frame(len);
      end
    end
  endtask

  // Hold the result side off while short frames keep coming, so the input stalls.
  task automatic test_backpressure();
    wait_idle();
    hold_req = 1'b1;
    frm.delete();
    repeat (3) frm.push_back(8'($urandom_range(0, 255)));
    repeat (15) send_frame(3);
  endtask

  task automatic test_no_idle();
    wait_idle();
    idle_on = 1'b0;
    stall_on = 1'b0;
    build_reply(5, xid_reg, want_type(), 3);
    close_frame();
    send_frame(frm.size());
    send_frame(20);
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_XID;
    cfg_data = '0;
    xid_reg = '0;
    ack_mode = 1'b0;
    clear_frame_state();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    test_no_idle();
    wait_idle();
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
